### rtl/b64d_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64d_pkg
// Shared types, constants and the character map of the base64 decoder.
// ----------------------------------------------------------------------------
package b64d_pkg;

    localparam logic [7:0] PAD_CHAR = 8'h3D;

    // One decoded group: up to three bytes, how many are valid, and whether
    // the last valid byte closes the message.
    typedef struct packed {
        logic [23:0] word;
        logic [1:0]  count;
        logic        last;
    } t_entry;

    function automatic logic [5:0] sextet_of(input logic [7:0] c);
        logic [5:0] v;
        v = 6'd0;
        if (c >= 8'h41 && c <= 8'h5A) begin
            v = 6'(c - 8'h41);
        end else if (c >= 8'h61 && c <= 8'h7A) begin
            v = 6'(c - 8'h61 + 8'd26);
        end else if (c >= 8'h30 && c <= 8'h39) begin
            v = 6'(c - 8'h30 + 8'd52);
        end else if (c == 8'h2B || c == 8'h2D || c == 8'h2E) begin
            v = 6'd62;
        end else if (c == 8'h2F || c == 8'h2C || c == 8'h5F) begin
            v = 6'd63;
        end
        return v;
    endfunction

endpackage

### rtl/b64d_char_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64d_char_if
// Character stream channel: one base64 character per beat.
// ----------------------------------------------------------------------------
interface b64d_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       last_char;

    modport source (output valid, output char_code, output last_char, input ready);
    modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

### rtl/b64d_byte_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64d_byte_if
// Byte stream channel: one decoded byte per beat.
// ----------------------------------------------------------------------------
interface b64d_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

### rtl/b64d_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64d_front
// Maps characters to sextets, gathers groups of four and pushes one group
// entry per full group or per message tail of two or three characters.
// ----------------------------------------------------------------------------
module b64d_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    b64d_char_if.sink         i_char,
    output logic              o_push,
    output b64d_pkg::t_entry  o_entry,
    input  logic              i_push_ready
);
    import b64d_pkg::*;

    logic [17:0] r_acc, n_acc;
    logic [1:0]  r_cnt, n_cnt;
    logic        r_third_pad, n_third_pad;

    logic        accept;
    logic [5:0]  idx;
    logic        is_pad;
    logic [23:0] word;
    logic [17:0] acc_sh;
    logic [1:0]  cnt_inc;

    assign i_char.ready = i_push_ready;
    assign accept       = i_char.valid && i_push_ready;
    assign idx          = sextet_of(i_char.char_code);
    assign is_pad       = (i_char.char_code == PAD_CHAR);
    assign word         = {r_acc, idx};
    assign acc_sh       = {r_acc[11:0], idx};
    assign cnt_inc      = r_cnt + 2'd1;

    always_comb begin
        n_acc       = r_acc;
        n_cnt       = r_cnt;
        n_third_pad = r_third_pad;
        o_push      = 1'b0;
        o_entry     = '{word: word, count: 2'd3, last: 1'b0};
        if (accept) begin
            if (r_cnt == 2'd3) begin
                o_push = 1'b1;
                if (i_char.last_char) begin
                    o_entry.last = 1'b1;
                    if (is_pad) begin
                        o_entry.count = r_third_pad ? 2'd1 : 2'd2;
                    end
                end
                n_acc       = '0;
                n_cnt       = '0;
                n_third_pad = 1'b0;
            end else begin
                n_acc = acc_sh;
                n_cnt = cnt_inc;
                if (r_cnt == 2'd2) begin
                    n_third_pad = is_pad;
                end
                if (i_char.last_char) begin
                    // flush the short tail
                    if (cnt_inc == 2'd2) begin
                        o_push  = 1'b1;
                        o_entry = '{word: {acc_sh[11:4], 16'd0}, count: 2'd1, last: 1'b1};
                    end else if (cnt_inc == 2'd3) begin
                        o_push  = 1'b1;
                        o_entry = '{word: {acc_sh[17:10], acc_sh[9:2], 8'd0},
                                    count: 2'd2, last: 1'b1};
                    end
                    n_acc       = '0;
                    n_cnt       = '0;
                    n_third_pad = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc       <= '0;
            r_cnt       <= '0;
            r_third_pad <= 1'b0;
        end else begin
            r_acc       <= n_acc;
            r_cnt       <= n_cnt;
            r_third_pad <= n_third_pad;
        end
    end

endmodule

### rtl/b64d_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64d_fifo
// Short queue of group entries between the front and the back.
// ----------------------------------------------------------------------------
module b64d_fifo #(
    parameter int DEPTH = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  b64d_pkg::t_entry  i_entry,
    output logic              o_ready,
    input  logic              i_pop,
    output logic              o_avail,
    output b64d_pkg::t_entry  o_entry
);
    import b64d_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LW = $clog2(DEPTH + 1);

    t_entry          r_mem [DEPTH];
    logic [AW-1:0]   r_wr, r_rd;
    logic [LW-1:0]   r_level;
    logic            do_push, do_pop;

    assign o_ready = (r_level != LW'(DEPTH));
    assign o_avail = (r_level != '0);
    assign o_entry = r_mem[r_rd];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_avail;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_level <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_level <= r_level + 1'b1;
            end else if (do_pop && !do_push) begin
                r_level <= r_level - 1'b1;
            end
        end
    end

endmodule

### rtl/b64d_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64d_back
// Takes group entries from the queue and sends their bytes one per beat
// from a held entry register.
// ----------------------------------------------------------------------------
module b64d_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_avail,
    input  b64d_pkg::t_entry  i_entry,
    output logic              o_pop,
    b64d_byte_if.source       o_byte
);
    import b64d_pkg::*;

    t_entry      r_ent;
    logic        r_valid;
    logic [1:0]  r_pos;
    logic        fire, final_beat, load;

    assign fire       = r_valid && o_byte.ready;
    assign final_beat = (r_pos == (r_ent.count - 2'd1));
    assign load       = (!r_valid || (fire && final_beat)) && i_avail;
    assign o_pop      = load;

    assign o_byte.valid     = r_valid;
    assign o_byte.last_byte = r_ent.last && final_beat;

    always_comb begin
        unique case (r_pos)
            2'd0:    o_byte.data_byte = r_ent.word[23:16];
            2'd1:    o_byte.data_byte = r_ent.word[15:8];
            default: o_byte.data_byte = r_ent.word[7:0];
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_ent <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_pos   <= '0;
        end else begin
            priority if (load) begin
                r_valid <= 1'b1;
                r_pos   <= '0;
            end else if (fire && final_beat) begin
                r_valid <= 1'b0;
                r_pos   <= '0;
            end else if (fire) begin
                r_pos <= r_pos + 2'd1;
            end
        end
    end

endmodule

### rtl/base64_stream_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// base64_stream_decoder
// Lenient streaming base64 decoder, one character in and one byte out per beat.
// ----------------------------------------------------------------------------
// The decoder takes one character every cycle while its group queue has room,
// and its back end sends one byte per cycle from its held entry while the byte
// sink is ready, so a stream of four characters gives three bytes at full rate
// with no gaps on the input. The first byte of a group is offered once its
// entry has passed through the queue into the back end's held entry register,
// which loads only when the back end is idle or sends its last byte. The queue
// holds DEPTH groups and the back end holds one more, so the input stalls only
// after DEPTH + 1 groups have piled up behind a stalled byte sink. The last
// character of a message flushes any short tail; a lone trailing character
// gives no byte.
module base64_stream_decoder #(
    parameter int DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    b64d_char_if.sink   i_char,
    b64d_byte_if.source o_byte
);
    import b64d_pkg::*;

    logic   f_push, f_push_ready;
    t_entry f_entry;
    logic   q_avail, b_pop;
    t_entry q_entry;

    b64d_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_char       (i_char),
        .o_push       (f_push),
        .o_entry      (f_entry),
        .i_push_ready (f_push_ready)
    );

    b64d_fifo #(.DEPTH(DEPTH)) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_entry (f_entry),
        .o_ready (f_push_ready),
        .i_pop   (b_pop),
        .o_avail (q_avail),
        .o_entry (q_entry)
    );

    b64d_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_avail (q_avail),
        .i_entry (q_entry),
        .o_pop   (b_pop),
        .o_byte  (o_byte)
    );

    a_push_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        f_push |-> f_push_ready)
        else $error("group pushed into a full queue");

    a_pop_has_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        b_pop |-> q_avail)
        else $error("group popped from an empty queue");

    a_no_phantom_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!q_avail && !o_byte.valid) |=> !o_byte.valid)
        else $error("byte offered with no group queued");

endmodule

### tb/base64_stream_decoder_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// base64_stream_decoder_tb
// Self-checking bench for the streaming base64 decoder. A queue of character
// beats (directed messages first, then random messages that are mostly valid
// base64 with padding, noise bytes and stray pad characters) feeds a bursty
// driver. Accepted characters run through a local decoder that fills a queue
// of expected bytes. A monitor with its own stall pattern checks every byte.
// ----------------------------------------------------------------------------
module base64_stream_decoder_tb;
    import b64d_pkg::*;

    localparam int RANDOM_CHARS   = 120;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int TAIL_CYCLES    = 16;

    typedef struct {
        logic [7:0] code;
        logic       last;
        logic       drain_first;
    } t_char_beat;

    typedef struct {
        logic [7:0] data;
        logic       last;
    } t_byte_beat;

    logic i_clk;
    logic i_rst_n;

    b64d_char_if char_bus ();
    b64d_byte_if byte_bus ();

    base64_stream_decoder dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_char  (char_bus.sink),
        .o_byte  (byte_bus.source)
    );

    t_char_beat pending_chars[$];
    t_byte_beat expected_bytes[$];

    logic [17:0] grp_acc;
    logic [1:0]  grp_count;
    logic        grp_pad3;

    int          error_count;
    int          burst_left;
    int          gap_left;
    int          idle_cycles;
    int          pat_age;
    logic [7:0]  stall_pat;
    t_char_beat  next_char;

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        $display("[%0t] mismatch on %s: got 0x%02h, expected 0x%02h", $realtime, what, got,
                 want);
        error_count++;
    endtask

    function automatic logic [5:0] char_value(input logic [7:0] c);
        if (c >= "A" && c <= "Z") return 6'(c - "A");
        if (c >= "a" && c <= "z") return 6'(c - "a" + 8'd26);
        if (c >= "0" && c <= "9") return 6'(c - "0" + 8'd52);
        if (c == "+" || c == "-" || c == ".") return 6'd62;
        if (c == "/" || c == "," || c == "_") return 6'd63;
        return 6'd0;
    endfunction

    function automatic void push_byte(input logic [7:0] data, input logic last);
        t_byte_beat b;
        b.data = data;
        b.last = last;
        expected_bytes.insert(expected_bytes.size(), b);
    endfunction

    // Advance the local decoder by one character and queue the bytes it yields.
    function automatic void decode_char(input logic [7:0] c, input logic last);
        logic [5:0]  v;
        logic [23:0] w;
        v = char_value(c);
        if (grp_count == 2'd3) begin
            w = {grp_acc, v};
            if (!last) begin
                push_byte(w[23:16], 1'b0);
                push_byte(w[15:8], 1'b0);
                push_byte(w[7:0], 1'b0);
            end else if (c == PAD_CHAR) begin
                if (grp_pad3) begin
                    push_byte(w[23:16], 1'b1);
                end else begin
                    push_byte(w[23:16], 1'b0);
                    push_byte(w[15:8], 1'b1);
                end
            end else begin
                push_byte(w[23:16], 1'b0);
                push_byte(w[15:8], 1'b0);
                push_byte(w[7:0], 1'b1);
            end
            grp_acc   = '0;
            grp_count = '0;
            grp_pad3  = 1'b0;
        end else begin
            grp_acc = {grp_acc[11:0], v};
            if (grp_count == 2'd2) grp_pad3 = (c == PAD_CHAR);
            grp_count = grp_count + 2'd1;
            if (last) begin
                if (grp_count == 2'd2) begin
                    push_byte(grp_acc[11:4], 1'b1);
                end else if (grp_count == 2'd3) begin
                    push_byte(grp_acc[17:10], 1'b0);
                    push_byte(grp_acc[9:2], 1'b1);
                end
                grp_acc   = '0;
                grp_count = '0;
                grp_pad3  = 1'b0;
            end
        end
    endfunction

    task automatic queue_char(input logic [7:0] code, input logic last, input logic drain);
        t_char_beat b;
        b.code        = code;
        b.last        = last;
        b.drain_first = drain;
        pending_chars.insert(pending_chars.size(), b);
    endtask

    task automatic queue_message(input string s, input logic drain);
        for (int i = 0; i < s.len(); i++) begin
            queue_char(s[i], i == s.len() - 1, drain && i == 0);
        end
    endtask

    // Driver: bursts of beats separated by random gaps.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            char_bus.valid <= 1'b0;
            burst_left     = $urandom_range(1, 12);
            gap_left       = 0;
        end else begin
            if (char_bus.valid && char_bus.ready) begin
                decode_char(char_bus.char_code, char_bus.last_char);
            end
            if (!char_bus.valid || char_bus.ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    char_bus.valid <= 1'b0;
                end else if (pending_chars.size() != 0 &&
                             !(pending_chars[0].drain_first && expected_bytes.size() != 0)) begin
                    next_char = pending_chars.pop_front();
                    char_bus.valid     <= 1'b1;
                    char_bus.char_code <= next_char.code;
                    char_bus.last_char <= next_char.last;
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = $urandom_range(1, 12);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
                    end
                end else begin
                    char_bus.valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each byte beat and stall on a rotating pattern.
    always @(posedge i_clk) begin
        t_byte_beat want;
        if (!i_rst_n) begin
            byte_bus.ready <= 1'b0;
            stall_pat      <= 8'hFF;
            pat_age        <= 0;
        end else begin
            if (byte_bus.valid && byte_bus.ready) begin
                if (expected_bytes.size() == 0) begin
                    report_mismatch("unexpected byte", byte_bus.data_byte, 8'h00);
                end else begin
                    want = expected_bytes.pop_front();
                    if (byte_bus.data_byte !== want.data)
                        report_mismatch("data_byte", byte_bus.data_byte, want.data);
                    if (byte_bus.last_byte !== want.last)
                        report_mismatch("last_byte", 8'(byte_bus.last_byte), 8'(want.last));
                end
            end
            if (pat_age == 63) begin
                pat_age   <= 0;
                stall_pat <= ($urandom_range(0, 3) == 0) ? 8'hFF : (8'($urandom) | 8'h01);
            end else begin
                pat_age   <= pat_age + 1;
                stall_pat <= {stall_pat[0], stall_pat[7:1]};
            end
            byte_bus.ready <= stall_pat[0];
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (char_bus.valid && char_bus.ready) ||
            (byte_bus.valid && byte_bus.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired after %0d idle cycles", idle_cycles);
            $display("CHECKS FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        string alphabet;
        int    len;
        int    pad;
        int    queued;
        logic [7:0] c;

        alphabet = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/-._,";
        i_rst_n            = 1'b0;
        char_bus.valid     = 1'b0;
        char_bus.char_code = 8'h00;
        char_bus.last_char = 1'b0;
        byte_bus.ready     = 1'b0;
        grp_acc            = '0;
        grp_count          = '0;
        grp_pad3           = 1'b0;
        error_count        = 0;
        idle_cycles        = 0;

        queue_message("TWFu", 1'b0);
        queue_message("+-./,_==", 1'b0);
        queue_message("Zz9=", 1'b0);
        queue_char(8'hFF, 1'b0, 1'b0);
        queue_char(8'h00, 1'b0, 1'b0);
        queue_char("A", 1'b1, 1'b0);
        queue_message("Q=", 1'b0);
        queue_message("Q", 1'b0);

        queued = 0;
        while (queued < RANDOM_CHARS) begin
            len = $urandom_range(1, 16);
            pad = 0;
            if (len % 4 == 0 && $urandom_range(0, 2) == 0) pad = $urandom_range(1, 2);
            for (int i = 0; i < len; i++) begin
                if (i >= len - pad || $urandom_range(0, 24) == 0) begin
                    c = PAD_CHAR;
                end else if ($urandom_range(0, 9) == 0) begin
                    c = 8'($urandom_range(0, 255));
                end else begin
                    c = alphabet[$urandom_range(0, alphabet.len() - 1)];
                end
                queue_char(c, i == len - 1,
                           i == 0 && (queued == 0 || $urandom_range(0, 9) == 0));
                queued++;
            end
        end

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        @(posedge i_clk);
        while (pending_chars.size() != 0 || char_bus.valid || expected_bytes.size() != 0)
            @(negedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (error_count == 0 && expected_bytes.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

### base64_stream_decoder.f
rtl/b64d_pkg.sv
rtl/b64d_char_if.sv
rtl/b64d_byte_if.sv
rtl/b64d_front.sv
rtl/b64d_fifo.sv
rtl/b64d_back.sv
rtl/base64_stream_decoder.sv
tb/base64_stream_decoder_tb.sv
